FILE: rtl/core/yuyv_color_pipeline_defines.svh
// Assertion macros used by the checker file.
`ifndef YUYV_COLOR_PIPELINE_DEFINES_SVH
`define YUYV_COLOR_PIPELINE_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define YCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define YCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ycp_pkg.sv
package ycp_pkg;
  localparam int unsigned CoefFracBits = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CCM_RED   = 3'd0,
    CFG_CCM_GREEN = 3'd1,
    CFG_CCM_BLUE  = 3'd2,
    CFG_CCM_OFS   = 3'd3,
    CFG_WB_GAINS  = 3'd4,
    CFG_WB_EN     = 3'd5
  } cfg_idx_e;

  localparam logic KindPixel = 1'b0;
  localparam logic KindGamma = 1'b1;

  // Saturate a signed value to 0..255.
  function automatic logic [7:0] sat_u8(input logic signed [31:0] x);
    logic [7:0] r;
    if (x < 0) r = 8'd0;
    else if (x > 32'sd255) r = 8'd255;
    else r = x[7:0];
    return r;
  endfunction
endpackage

FILE: rtl/core/ycp_ram.sv
module ycp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/core/yuyv_color_pipeline.sv
// Throughput: one item per cycle while the output is not blocked; a gamma write takes the slot and yields no result.
// Three gamma table copies give three reads per cycle for the three channels.
// Reset clears all valid bits and loads the register defaults.
// The gamma table is not cleared by reset and must be written before use.
module yuyv_color_pipeline #(
  parameter int unsigned CoefFracBits = ycp_pkg::CoefFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // luma_first, chroma_u, luma_second, chroma_v, table_index, table_value
  input  logic [ycp_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  // kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // luma_out, u_out, v_out
  output logic [ycp_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [ycp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ycp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ycp_pkg::*;

  localparam int unsigned NStg = 8;

  // Configuration registers.
  logic [47:0] ccm_r_q, ccm_g_q, ccm_b_q, gains_q;
  logic [26:0] ofs_q;
  logic        wb_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccm_r_q <= 48'd4096;
      ccm_g_q <= 48'd4096 << 16;
      ccm_b_q <= 48'd4096 << 32;
      ofs_q   <= '0;
      gains_q <= 48'd70369817935872;
      wb_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CCM_RED:   ccm_r_q <= cfg_data_i;
        CFG_CCM_GREEN: ccm_g_q <= cfg_data_i;
        CFG_CCM_BLUE:  ccm_b_q <= cfg_data_i;
        CFG_CCM_OFS:   ofs_q   <= cfg_data_i[26:0];
        CFG_WB_GAINS:  gains_q <= cfg_data_i;
        CFG_WB_EN:     wb_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: valid bits per stage, stall when output is blocked.
  logic [NStg-1:0] vld_q;
  logic            adv;
  assign adv = !vld_q[NStg-1] || m_axis_tready;
  assign s_axis_tready = adv;

  logic in_pix, in_gam;
  assign in_pix = s_axis_tvalid && adv && (s_axis_tuser == KindPixel);
  assign in_gam = s_axis_tvalid && adv && (s_axis_tuser == KindGamma);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NStg-2:0], in_pix};
  end

  logic [NStg-1:0] last_q;
  always_ff @(posedge clk_i) begin
    if (adv) last_q <= {last_q[NStg-2:0], s_axis_tlast};
  end

  // Stage 1: YUV to RGB products.
  logic signed [31:0] s1_r_q, s1_g_q, s1_b_q;
  logic signed [8:0]  du, dv;
  assign du = $signed({1'b0, s_axis_tdata[15:8]}) - 9'sd128;
  assign dv = $signed({1'b0, s_axis_tdata[31:24]}) - 9'sd128;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_r_q <= $signed({8'd0, s_axis_tdata[7:0], 16'd0}) + 32'sd91881 * dv;
      s1_g_q <= $signed({8'd0, s_axis_tdata[7:0], 16'd0}) - 32'sd22544 * du
                - 32'sd46793 * dv;
      s1_b_q <= $signed({8'd0, s_axis_tdata[7:0], 16'd0}) + 32'sd116130 * du;
    end
  end

  // Truncate toward zero then clamp.
  function automatic logic [7:0] q16_trunc(input logic signed [31:0] s);
    logic signed [31:0] t;
    t = s / 32'sd65536;
    return sat_u8(t);
  endfunction

  // Stage 2: clamp RGB.
  logic [7:0] s2_r_q, s2_g_q, s2_b_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_r_q <= q16_trunc(s1_r_q);
      s2_g_q <= q16_trunc(s1_g_q);
      s2_b_q <= q16_trunc(s1_b_q);
    end
  end

  // Stage 3: white-balance products.
  logic [23:0] s3_r_q, s3_g_q, s3_b_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_r_q <= wb_en_q ? s2_r_q * gains_q[15:0]  : {2'd0, s2_r_q, 14'd0};
      s3_g_q <= wb_en_q ? s2_g_q * gains_q[31:16] : {2'd0, s2_g_q, 14'd0};
      s3_b_q <= wb_en_q ? s2_b_q * gains_q[47:32] : {2'd0, s2_b_q, 14'd0};
    end
  end

  function automatic logic [7:0] wb_sat(input logic [23:0] p);
    return (p[23:14] > 10'd255) ? 8'd255 : p[21:14];
  endfunction

  // Stage 4: saturate white balance.
  logic [7:0] s4_r_q, s4_g_q, s4_b_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_r_q <= wb_sat(s3_r_q);
      s4_g_q <= wb_sat(s3_g_q);
      s4_b_q <= wb_sat(s3_b_q);
    end
  end

  // Stage 5: matrix row sums, one multiply per term.
  function automatic logic signed [31:0] mrow(input logic [47:0] row,
      input logic signed [8:0] off, input logic [7:0] r, input logic [7:0] g,
      input logic [7:0] b);
    logic signed [31:0] a;
    a = $signed(row[15:0]) * $signed({1'b0, r}) + $signed(row[31:16]) * $signed({1'b0, g})
        + $signed(row[47:32]) * $signed({1'b0, b}) + (32'(off) <<< CoefFracBits);
    return a;
  endfunction

  logic signed [31:0] s5_r_q, s5_g_q, s5_b_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_r_q <= mrow(ccm_r_q, $signed(ofs_q[8:0]), s4_r_q, s4_g_q, s4_b_q);
      s5_g_q <= mrow(ccm_g_q, $signed(ofs_q[17:9]), s4_r_q, s4_g_q, s4_b_q);
      s5_b_q <= mrow(ccm_b_q, $signed(ofs_q[26:18]), s4_r_q, s4_g_q, s4_b_q);
    end
  end

  function automatic logic [7:0] mclamp(input logic signed [31:0] a);
    return sat_u8(a >>> CoefFracBits);
  endfunction

  // Gamma writes travel in their own slot and land at the lookup stage, so
  // every pixel sees the table as it stood when that pixel was accepted.
  localparam int unsigned GamStg = 5;
  logic [GamStg-1:0] gv_q;
  // Each entry holds the table value over the table index.
  logic [15:0]       gw_q [GamStg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gv_q <= '0;
    else if (adv) gv_q <= {gv_q[GamStg-2:0], in_gam};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gw_q[0] <= s_axis_tdata[47:32];
      for (int i = 1; i < GamStg; i++) gw_q[i] <= gw_q[i-1];
    end
  end

  // Stage 6: gamma lookup, three RAM copies with registered reads.
  logic [7:0] gam_r, gam_g, gam_b;
  logic       gwe;
  assign gwe = gv_q[GamStg-1] && adv;

  ycp_ram #(.Width(8), .Depth(256)) u_gam_r (
    .clk_i, .we_i(gwe), .waddr_i(gw_q[GamStg-1][7:0]), .wdata_i(gw_q[GamStg-1][15:8]),
    .re_i(adv), .raddr_i(mclamp(s5_r_q)), .rdata_o(gam_r));
  ycp_ram #(.Width(8), .Depth(256)) u_gam_g (
    .clk_i, .we_i(gwe), .waddr_i(gw_q[GamStg-1][7:0]), .wdata_i(gw_q[GamStg-1][15:8]),
    .re_i(adv), .raddr_i(mclamp(s5_g_q)), .rdata_o(gam_g));
  ycp_ram #(.Width(8), .Depth(256)) u_gam_b (
    .clk_i, .we_i(gwe), .waddr_i(gw_q[GamStg-1][7:0]), .wdata_i(gw_q[GamStg-1][15:8]),
    .re_i(adv), .raddr_i(mclamp(s5_b_q)), .rdata_o(gam_b));

  // Stage 7: RGB to YUV sums.
  logic signed [31:0] s7_y_q, s7_u_q, s7_v_q;
  logic signed [31:0] cr, cg, cb;
  assign cr = $signed({24'd0, gam_r});
  assign cg = $signed({24'd0, gam_g});
  assign cb = $signed({24'd0, gam_b});
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_y_q <= 32'sd19595 * cr + 32'sd38470 * cg + 32'sd7471 * cb;
      s7_u_q <= -32'sd9634 * cr - 32'sd18940 * cg + 32'sd28574 * cb + 32'sd8388608;
      s7_v_q <= 32'sd40305 * cr - 32'sd33751 * cg - 32'sd6554 * cb + 32'sd8388608;
    end
  end

  // Stage 8: output register.
  logic [23:0] out_q;
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= {sat_u8(s7_v_q >>> 16), sat_u8(s7_u_q >>> 16), sat_u8(s7_y_q >>> 16)};
  end

  assign m_axis_tvalid = vld_q[NStg-1];
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = last_q[NStg-1];
endmodule

FILE: rtl/core/ycp_checker.sv
`include "yuyv_color_pipeline_defines.svh"
module ycp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  // A result is waiting on the receiver.
  logic stall;
  assign stall = m_axis_tvalid && !m_axis_tready;

  // A blocked result keeps its data.
  `YCP_ASSERT_NXT(a_hold, clk_i, rst_ni, stall, $stable(m_axis_tdata), "result changed")
  // Input is ready whenever the output is empty or drained.
  `YCP_ASSERT_IMP(a_rdy, clk_i, rst_ni, !stall, s_axis_tready, "input not ready")
  // A stalled result stays valid.
  `YCP_ASSERT_NXT(a_vld, clk_i, rst_ni, stall, m_axis_tvalid, "result dropped")
endmodule

bind yuyv_color_pipeline ycp_checker u_ycp_checker (.*);
